@@ src/r2fft_pkg.sv @@
package r2fft_pkg;

   localparam int POINT_W = 48;

   typedef struct packed {
      logic signed [15:0] in_re;
      logic signed [15:0] in_im;
   } r2fft_req_type;

   typedef struct packed {
      logic signed [23:0] out_re;
      logic signed [23:0] out_im;
      logic               out_last;
   } r2fft_rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_A,
      ST_RD_B,
      ST_MUL,
      ST_SUM,
      ST_ADD,
      ST_WR_A,
      ST_WR_B,
      ST_EMIT_RD,
      ST_EMIT_LD
   } r2fft_state_type;

   typedef enum logic [1:0] {
      WR_SAMPLE,
      WR_A,
      WR_B
   } r2fft_wr_src_type;

   localparam logic [1:0] CSR_INVERSE = 2'd0;
   localparam logic [1:0] CSR_LOG2    = 2'd1;

   typedef struct packed {
      logic              wr_en;
      r2fft_wr_src_type  wr_src;
      logic              rd_en;
      logic              tw_en;
      logic              cap_a;
      logic              mul_en;
      logic              sum_en;
      logic              add_en;
      logic [4:0]        tw_k;
      logic              inv;
      logic [2:0]        lg;
      logic              out_load;
      logic              out_last;
   } r2fft_cmd_type;

   typedef struct packed {
      logic out_free;
   } r2fft_status_type;

   typedef struct packed {
      logic signed [16:0] c;
      logic signed [16:0] s;
   } r2fft_tw_type;

   localparam logic signed [16:0] QUARTER_COS [17] = '{
      17'sd32767, 17'sd32609, 17'sd32137, 17'sd31356, 17'sd30273, 17'sd28898,
      17'sd27245, 17'sd25329, 17'sd23170, 17'sd20787, 17'sd18204, 17'sd15446,
      17'sd12539, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
   };

   // quarter wave table, second quadrant by symmetry
   function automatic r2fft_tw_type twiddle(input logic [4:0] k);
      r2fft_tw_type t;
      if (k <= 5'd16) begin
         t.c = QUARTER_COS[k];
         t.s = QUARTER_COS[5'd16 - k];
      end else begin
         t.c = -QUARTER_COS[5'd0 - k];
         t.s = QUARTER_COS[k - 5'd16];
      end
      return t;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -28'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

@@ src/r2fft_ram.sv @@
module r2fft_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/r2fft_ctrl.sv @@
module r2fft_ctrl #(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [2:0]                      csr_wdata,
   input  r2fft_pkg::r2fft_status_type     status,
   output r2fft_pkg::r2fft_cmd_type        cmd,
   output logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
   output logic [$clog2(MAX_POINTS)-1:0]   rd_addr
);
   import r2fft_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_POINTS);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int LOG_MAX = ($clog2(MAX_POINTS + 1) - 1) > 6 ? 6 : ($clog2(MAX_POINTS + 1) - 1);

   r2fft_state_type     state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   bf_ff, bf_in;
   logic [2:0]          st_ff, st_in;
   logic [ADDR_W-1:0]   pt_ff, pt_in;
   logic                inv_ff, inv_in;
   logic [2:0]          log2_ff, log2_in;

   logic [2:0]          lg;
   logic [CNT_W-1:0]    n;
   logic [CNT_W-1:0]    n_m1;
   logic [CNT_W-1:0]    last_bf;
   logic [ADDR_W-1:0]   rev_full;
   logic [ADDR_W-1:0]   rev;
   logic [CNT_W-1:0]    mask_lo;
   logic [CNT_W-1:0]    half_w;
   logic [CNT_W-1:0]    a_wide;
   logic [CNT_W-1:0]    j_wide;
   logic [5:0]          k_wide;
   logic [ADDR_W-1:0]   addr_a;
   logic [ADDR_W-1:0]   addr_b;

   always_comb begin
      if (log2_ff < 3'd1) begin
         lg = 3'd1;
      end else if (log2_ff > 3'(LOG_MAX)) begin
         lg = 3'(LOG_MAX);
      end else begin
         lg = log2_ff;
      end
   end

   assign n       = CNT_W'(1) << lg;
   assign n_m1    = n - CNT_W'(1);
   assign last_bf = (n >> 1) - CNT_W'(1);

   // samples land at their bit reversed place, so no swap pass is needed
   always_comb begin
      for (int b = 0; b < ADDR_W; b++) begin
         rev_full[b] = count_ff[ADDR_W-1-b];
      end
   end
   assign rev = rev_full >> (3'(ADDR_W) - lg);

   // butterfly pair: a zero bit is inserted at the stage position
   assign half_w  = CNT_W'(1) << st_ff;
   assign mask_lo = half_w - CNT_W'(1);
   assign j_wide  = {1'b0, bf_ff} & mask_lo;
   assign a_wide  = (({1'b0, bf_ff} & ~mask_lo) << 1) | j_wide;
   assign addr_a  = a_wide[ADDR_W-1:0];
   assign addr_b  = addr_a | half_w[ADDR_W-1:0];
   assign k_wide  = 6'(j_wide) << (3'd5 - st_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         bf_ff    <= '0;
         st_ff    <= '0;
         pt_ff    <= '0;
         inv_ff   <= 1'b0;
         log2_ff  <= 3'd6;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bf_ff    <= bf_in;
         st_ff    <= st_in;
         pt_ff    <= pt_in;
         inv_ff   <= inv_in;
         log2_ff  <= log2_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      bf_in     = bf_ff;
      st_in     = st_ff;
      pt_in     = pt_ff;
      inv_in    = inv_ff;
      log2_in   = log2_ff;
      req_stall = 1'b1;
      wr_addr   = rev;
      rd_addr   = addr_a;

      cmd          = '0;
      cmd.wr_src   = WR_SAMPLE;
      cmd.tw_k     = k_wide[4:0];
      cmd.inv      = inv_ff;
      cmd.lg       = lg;
      cmd.out_last = (CNT_W'(pt_ff) == n_m1);

      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               if (count_ff == n_m1) begin
                  count_in = '0;
                  bf_in    = '0;
                  st_in    = '0;
                  state_in = ST_RD_A;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_RD_A: begin
            cmd.rd_en  = 1'b1;
            cmd.tw_en  = 1'b1;
            rd_addr    = addr_a;
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_en = 1'b1;
            cmd.cap_a = 1'b1;
            rd_addr   = addr_b;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = ST_WR_A;
         end
         ST_WR_A: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_A;
            wr_addr    = addr_a;
            state_in   = ST_WR_B;
         end
         ST_WR_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_B;
            wr_addr    = addr_b;
            if (CNT_W'(bf_ff) == last_bf) begin
               bf_in = '0;
               if (st_ff == lg - 3'd1) begin
                  pt_in    = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  st_in    = st_ff + 3'd1;
                  state_in = ST_RD_A;
               end
            end else begin
               bf_in    = bf_ff + ADDR_W'(1);
               state_in = ST_RD_A;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = pt_ff;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (CNT_W'(pt_ff) == n_m1) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  pt_in    = pt_ff + ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_INVERSE: inv_in = csr_wdata[0];
            CSR_LOG2: begin
               log2_in  = csr_wdata;
               count_in = '0;
            end
            default: ;
         endcase
      end
   end

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> count_ff < n)
      else $error("sample count beyond block size");

   a_full_block_starts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && req_valid && count_ff == n_m1 && !csr_we
      |=> state_ff == ST_RD_A)
      else $error("full block did not start the transform");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free && state_ff == ST_EMIT_LD)
      else $error("point loaded into a busy output register");

endmodule

@@ src/r2fft_datapath.sv @@
module r2fft_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  r2fft_pkg::r2fft_cmd_type        cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
   input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
   input  r2fft_pkg::r2fft_req_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output r2fft_pkg::r2fft_rsp_type        rsp_data,
   output r2fft_pkg::r2fft_status_type     status
);
   import r2fft_pkg::*;

   logic [POINT_W-1:0]  wr_data;
   logic [POINT_W-1:0]  rd_data;
   logic signed [23:0]  rd_re, rd_im;

   r2fft_tw_type        tw_ff, tw_in;
   logic signed [23:0]  a_re_ff, a_im_ff;
   logic signed [40:0]  cr_ff, si_ff, ci_ff, sr_ff;
   logic signed [41:0]  sum_re, sum_im;
   logic signed [26:0]  pr_ff, pi_ff;
   logic signed [23:0]  ra_re_ff, ra_im_ff, rb_re_ff, rb_im_ff;
   logic                ov_ff, ov_in;
   r2fft_rsp_type       out_ff, out_in;

   r2fft_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_re = rd_data[47:24];
   assign rd_im = rd_data[23:0];

   always_comb begin
      case (cmd.wr_src)
         WR_SAMPLE: wr_data = {24'(req_data.in_re), 24'(req_data.in_im)};
         WR_A:      wr_data = {ra_re_ff, ra_im_ff};
         WR_B:      wr_data = {rb_re_ff, rb_im_ff};
         default:   wr_data = {ra_re_ff, ra_im_ff};
      endcase
   end

   // inverse uses the conjugate twiddle
   always_comb begin
      tw_in = twiddle(cmd.tw_k);
      if (cmd.inv) begin
         tw_in.s = -tw_in.s;
      end
   end

   assign sum_re = 42'(cr_ff) - 42'(si_ff) + 42'sd16384;
   assign sum_im = 42'(ci_ff) + 42'(sr_ff) + 42'sd16384;

   always_ff @(posedge clock) begin
      if (cmd.tw_en) begin
         tw_ff <= tw_in;
      end
      if (cmd.cap_a) begin
         a_re_ff <= rd_re;
         a_im_ff <= rd_im;
      end
      if (cmd.mul_en) begin
         cr_ff <= tw_ff.c * rd_re;
         si_ff <= tw_ff.s * rd_im;
         ci_ff <= tw_ff.c * rd_im;
         sr_ff <= tw_ff.s * rd_re;
      end
      if (cmd.sum_en) begin
         pr_ff <= 27'(sum_re >>> 15);
         pi_ff <= 27'(sum_im >>> 15);
      end
      if (cmd.add_en) begin
         ra_re_ff <= sat24(28'(a_re_ff) + 28'(pr_ff));
         ra_im_ff <= sat24(28'(a_im_ff) + 28'(pi_ff));
         rb_re_ff <= sat24(28'(a_re_ff) - 28'(pr_ff));
         rb_im_ff <= sat24(28'(a_im_ff) - 28'(pi_ff));
      end
   end

   // rounded divide by the block size
   function automatic logic signed [23:0] scale_down(input logic signed [23:0] v,
                                                     input logic [2:0] lg);
      logic signed [24:0] t;
      t = 25'(v) + (25'sd1 <<< (lg - 3'd1));
      return 24'(t >>> lg);
   endfunction

   always_comb begin
      out_in          = out_ff;
      ov_in           = ov_ff;
      status.out_free = !ov_ff || !rsp_stall;
      if (cmd.out_load) begin
         out_in.out_re   = cmd.inv ? scale_down(rd_re, cmd.lg) : rd_re;
         out_in.out_im   = cmd.inv ? scale_down(rd_im, cmd.lg) : rd_im;
         out_in.out_last = cmd.out_last;
         ov_in           = 1'b1;
      end else if (!rsp_stall) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

@@ src/radix2_complex_fft.sv @@
// Radix-2 decimation-in-time FFT over 2^log2_points complex Q1.15 samples
// (2 to MAX_POINTS points, at most 64). Samples are taken one a cycle while
// loading (req_stall is high otherwise) and written straight to their
// bit-reversed place in the point store; once the block is full the transform
// runs with one shared butterfly that reads A, reads B, multiplies, sums, adds,
// then writes A and B, set by the single read and write port of the store;
// then the points are read out and sent in index order as the output register
// frees, the final one marked by out_last. Inverse mode uses conjugate twiddles
// and a rounded divide by N; all results saturate to 24 bits.
module radix2_complex_fft #(
   parameter int MAX_POINTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  r2fft_pkg::r2fft_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output r2fft_pkg::r2fft_rsp_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [2:0]               csr_wdata
);
   import r2fft_pkg::*;

   r2fft_cmd_type                  cmd;
   r2fft_status_type               status;
   logic [$clog2(MAX_POINTS)-1:0]  wr_addr;
   logic [$clog2(MAX_POINTS)-1:0]  rd_addr;

   r2fft_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   r2fft_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule
